/* hdl/u8dec_pkg.sv */
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants for the UTF-8 stream decoder
// Field widths, result queue sizing, sequence length codes and the lead byte
// classifier used by the decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  // Payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned COUNT_W = 3;

  // Result queue sizing
  localparam int unsigned FIFO_DEPTH  = 8;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W      = PTR_W + 1;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned NUM_W       = $clog2(MAX_RESULTS + 1);

  // Buffered bytes of an open sequence
  localparam int unsigned PEND_DEPTH = 3;

  // Sequence length codes
  localparam logic [COUNT_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [COUNT_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [COUNT_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
  localparam logic [COUNT_W-1:0] LEN_FOUR  = 3'd4;

  // Lead byte masks and patterns
  localparam logic [BYTE_W-1:0] MASK_TWO    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_TWO    = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_THREE  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_THREE  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_FOUR   = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_FOUR   = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_CONT   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_MARK   = 8'h80;

  // One queued result
  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] byte_count;
    logic               passed_through;
    logic               last_of_run;
  } result_t;

  // Length of the sequence a byte opens, LEN_NONE if it is no lead
  function automatic logic [COUNT_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [COUNT_W-1:0] len;
    len = LEN_NONE;
    if ((b & MASK_TWO) == LEAD_TWO) begin
      len = LEN_TWO;
    end else if ((b & MASK_THREE) == LEAD_THREE) begin
      len = LEN_THREE;
    end else if ((b & MASK_FOUR) == LEAD_FOUR) begin
      len = LEN_FOUR;
    end
    return len;
  endfunction

endpackage

/* hdl/u8dec_byte_if.sv */
// ----------------------------------------------------------------------------
// u8dec_byte_if: byte request channel
// Valid/ready channel carrying one raw text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface u8dec_byte_if;
  logic                          valid;
  logic                          ready;
  logic [u8dec_pkg::BYTE_W-1:0]  byte_value;
  logic                          end_of_text;

  modport source (output valid, output byte_value, output end_of_text, input ready);
  modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

/* hdl/u8dec_result_if.sv */
// ----------------------------------------------------------------------------
// u8dec_result_if: decoded result channel
// Valid/ready channel carrying one code point or raw byte with its flags.
// ----------------------------------------------------------------------------
interface u8dec_result_if;
  logic                          valid;
  logic                          ready;
  logic [u8dec_pkg::CP_W-1:0]    code_point;
  logic [u8dec_pkg::COUNT_W-1:0] byte_count;
  logic                          passed_through;
  logic                          last_of_run;

  modport source (output valid, output code_point, output byte_count,
                  output passed_through, output last_of_run, input ready);
  modport sink   (input valid, input code_point, input byte_count,
                  input passed_through, input last_of_run, output ready);
endinterface

/* hdl/utf8_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: streaming UTF-8 decoder
// Decodes one byte per request into code points; broken or invalid bytes are
// passed through raw. Results leave through an eight-entry result queue.
// ----------------------------------------------------------------------------
// One byte request is taken per clock while the result queue has room for
// four results; the decode of a byte (sequence tracking, code point assembly
// and the raw flush of a broken sequence) settles in the cycle it is accepted
// and writes its zero to four results into the queue at once. Results leave
// one per clock while the receiver takes them, so the sustained rate is then one
// byte per cycle: a byte never yields more results than the bytes it closes out.
// The byte request ready falls only while more than four results wait in the queue.
module utf8_stream_decoder_unit (
  input  logic             clk,
  input  logic             rst,
  u8dec_byte_if.sink       byte_chan,
  u8dec_result_if.source   result_chan
);

  // Open sequence state
  logic [u8dec_pkg::BYTE_W-1:0]  pending_bytes [u8dec_pkg::PEND_DEPTH];
  logic [1:0]                    pending_count;
  logic [u8dec_pkg::COUNT_W-1:0] expected_length;

  // Result queue
  u8dec_pkg::result_t            fifo [u8dec_pkg::FIFO_DEPTH];
  logic [u8dec_pkg::PTR_W-1:0]   rd_ptr;
  logic [u8dec_pkg::PTR_W-1:0]   wr_ptr;
  logic [u8dec_pkg::FILL_W-1:0]  fill_count;

  // Decode signals
  logic [u8dec_pkg::BYTE_W-1:0]  b;
  logic                          eot;
  logic                          is_cont;
  logic                          seq_open;
  logic                          completes;
  logic [u8dec_pkg::COUNT_W-1:0] fresh_len;
  logic [u8dec_pkg::CP_W-1:0]    assembled;
  logic [1:0]                    flush_n;
  logic                          tail_valid;
  u8dec_pkg::result_t            tail;
  logic                          store_cont;
  logic                          store_lead;
  logic [1:0]                    pending_count_next;
  logic [u8dec_pkg::COUNT_W-1:0] expected_length_next;
  logic [u8dec_pkg::NUM_W-1:0]   num_results;
  u8dec_pkg::result_t            slot [u8dec_pkg::MAX_RESULTS];
  logic                          byte_accept;
  logic                          pop;

  assign b           = byte_chan.byte_value;
  assign eot         = byte_chan.end_of_text;
  assign byte_accept = byte_chan.valid && byte_chan.ready;
  assign pop         = result_chan.valid && result_chan.ready;

  assign is_cont   = (b & u8dec_pkg::MASK_CONT) == u8dec_pkg::CONT_MARK;
  assign seq_open  = expected_length != u8dec_pkg::LEN_NONE;
  assign completes = ({1'b0, pending_count} + 3'd1) >= expected_length;
  assign fresh_len = u8dec_pkg::lead_length(b);

  // Assemble the code point of a sequence closed by this continuation
  always_comb begin
    unique case (expected_length)
      u8dec_pkg::LEN_TWO: begin
        assembled = {10'd0, pending_bytes[0][4:0], b[5:0]};
      end
      u8dec_pkg::LEN_THREE: begin
        assembled = {5'd0, pending_bytes[0][3:0], pending_bytes[1][5:0], b[5:0]};
      end
      default: begin
        assembled = {pending_bytes[0][2:0], pending_bytes[1][5:0],
                     pending_bytes[2][5:0], b[5:0]};
      end
    endcase
  end

  // Classify the byte: flushed raw bytes first, then at most one tail result
  always_comb begin
    flush_n              = 2'd0;
    tail_valid           = 1'b0;
    tail.code_point      = {13'd0, b};
    tail.byte_count      = u8dec_pkg::LEN_ONE;
    tail.passed_through  = 1'b1;
    tail.last_of_run     = 1'b0;
    store_cont           = 1'b0;
    store_lead           = 1'b0;
    pending_count_next   = pending_count;
    expected_length_next = expected_length;
    if (seq_open && is_cont) begin
      if (completes) begin
        tail_valid           = 1'b1;
        tail.code_point      = assembled;
        tail.byte_count      = expected_length;
        tail.passed_through  = 1'b0;
        pending_count_next   = 2'd0;
        expected_length_next = u8dec_pkg::LEN_NONE;
      end else begin
        store_cont = 1'b1;
        if (eot) begin
          flush_n              = pending_count;
          tail_valid           = 1'b1;
          pending_count_next   = 2'd0;
          expected_length_next = u8dec_pkg::LEN_NONE;
        end else begin
          pending_count_next = pending_count + 2'd1;
        end
      end
    end else begin
      flush_n              = seq_open ? pending_count : 2'd0;
      pending_count_next   = 2'd0;
      expected_length_next = u8dec_pkg::LEN_NONE;
      if (!b[7]) begin
        tail_valid          = 1'b1;
        tail.passed_through = 1'b0;
      end else if (fresh_len == u8dec_pkg::LEN_NONE) begin
        tail_valid = 1'b1;
      end else begin
        store_lead = 1'b1;
        if (eot) begin
          tail_valid = 1'b1;
        end else begin
          pending_count_next   = 2'd1;
          expected_length_next = fresh_len;
        end
      end
    end
  end

  assign num_results = {1'b0, flush_n} + {2'd0, tail_valid};

  // Lay out the results in order and mark the final one
  always_comb begin
    for (int i = 0; i < u8dec_pkg::PEND_DEPTH; i++) begin
      if (2'(i) < flush_n) begin
        slot[i].code_point     = {13'd0, pending_bytes[i]};
        slot[i].byte_count     = u8dec_pkg::LEN_ONE;
        slot[i].passed_through = 1'b1;
      end else begin
        slot[i].code_point     = tail.code_point;
        slot[i].byte_count     = tail.byte_count;
        slot[i].passed_through = tail.passed_through;
      end
      slot[i].last_of_run = (u8dec_pkg::NUM_W'(i) + 3'd1) == num_results;
    end
    slot[u8dec_pkg::MAX_RESULTS-1]             = tail;
    slot[u8dec_pkg::MAX_RESULTS-1].last_of_run =
      u8dec_pkg::NUM_W'(u8dec_pkg::MAX_RESULTS) == num_results;
  end

  // Advance sequence state and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count   <= 2'd0;
      expected_length <= u8dec_pkg::LEN_NONE;
      rd_ptr          <= '0;
      wr_ptr          <= '0;
      fill_count      <= '0;
    end else begin
      if (byte_accept) begin
        pending_count   <= pending_count_next;
        expected_length <= expected_length_next;
        wr_ptr          <= wr_ptr + u8dec_pkg::PTR_W'(num_results);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill_count <= fill_count
                    + (byte_accept ? u8dec_pkg::FILL_W'(num_results) : '0)
                    - u8dec_pkg::FILL_W'(pop);
    end
  end

  // Hold buffered lead and continuation bytes
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      if (store_lead) begin
        pending_bytes[0] <= b;
      end
      for (int j = 0; j < u8dec_pkg::PEND_DEPTH; j++) begin
        if (store_cont && pending_count == 2'(j)) begin
          pending_bytes[j] <= b;
        end
      end
    end
  end

  // Write this byte's results into the queue
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      for (int i = 0; i < u8dec_pkg::MAX_RESULTS; i++) begin
        if (u8dec_pkg::NUM_W'(i) < num_results) begin
          fifo[wr_ptr + u8dec_pkg::PTR_W'(i)] <= slot[i];
        end
      end
    end
  end

  // Channel outputs
  assign byte_chan.ready =
    fill_count <= u8dec_pkg::FILL_W'(u8dec_pkg::FIFO_DEPTH - u8dec_pkg::MAX_RESULTS);
  assign result_chan.valid          = fill_count != '0;
  assign result_chan.code_point     = fifo[rd_ptr].code_point;
  assign result_chan.byte_count     = fifo[rd_ptr].byte_count;
  assign result_chan.passed_through = fifo[rd_ptr].passed_through;
  assign result_chan.last_of_run    = fifo[rd_ptr].last_of_run;

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= u8dec_pkg::FILL_W'(u8dec_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // An open sequence always has buffered bytes, and only then
  assert property (@(posedge clk) disable iff (rst)
    (expected_length == u8dec_pkg::LEN_NONE) == (pending_count == 2'd0))
    else $error("sequence length and buffered count disagree");

  // End of text leaves no sequence open
  assert property (@(posedge clk) disable iff (rst)
    byte_accept && eot |=> expected_length == u8dec_pkg::LEN_NONE)
    else $error("sequence left open after end of text");

  // Reset empties the result queue
  assert property (@(posedge clk) rst |=> !result_chan.valid)
    else $error("result valid after reset");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UTF-8 stream decoder
// Drives byte requests through the valid/ready byte channel and checks every
// decoded result against typed-in results or an in-bench decoder. A directed
// table covers the extremes, broken sequences and end-of-text flushes. Random
// text follows, mostly well-formed characters with some noise, under several
// idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8dec_pkg::*;

  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_LIMIT = 20000;
  localparam result_t NO_RES = '0;

  // One row of directed stimulus; res holds typed-in results when fixed
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eot;
    logic              fixed;
    logic [2:0]        nres;
    result_t [3:0]     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  u8dec_byte_if   byte_chan ();
  u8dec_result_if result_chan ();

  utf8_stream_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .byte_chan   (byte_chan),
    .result_chan (result_chan)
  );

  always #1 clk = ~clk;

  // Decoder state mirrored by the bench
  logic [BYTE_W-1:0]  seq_bytes [PEND_DEPTH];
  int                 seq_fill;
  logic [COUNT_W-1:0] seq_len;

  // Results of the byte just decoded
  result_t run_res [MAX_RESULTS];
  int      run_n;

  result_t   code_points_due [$];
  stim_row_t directed_rows [$];

  int   err_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;

  function automatic result_t mk_res(input logic [CP_W-1:0] cp, input logic [COUNT_W-1:0] cnt,
                                     input logic raw, input logic last);
    result_t r;
    r.code_point     = cp;
    r.byte_count     = cnt;
    r.passed_through = raw;
    r.last_of_run    = last;
    return r;
  endfunction

  function automatic stim_row_t row_plain(input logic [BYTE_W-1:0] data, input logic eot);
    stim_row_t r;
    r       = '0;
    r.data  = data;
    r.eot   = eot;
    return r;
  endfunction

  function automatic stim_row_t row_exp(input logic [BYTE_W-1:0] data, input logic eot,
                                        input logic [2:0] nres, input result_t r0,
                                        input result_t r1, input result_t r2,
                                        input result_t r3);
    stim_row_t r;
    r        = '0;
    r.data   = data;
    r.eot    = eot;
    r.fixed  = 1'b1;
    r.nres   = nres;
    r.res[0] = r0;
    r.res[1] = r1;
    r.res[2] = r2;
    r.res[3] = r3;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Append one result of the current byte
  task automatic emit_result(input logic [CP_W-1:0] cp, input logic [COUNT_W-1:0] cnt,
                             input logic raw);
    run_res[run_n] = mk_res(cp, cnt, raw, 1'b0);
    run_n++;
  endtask

  // Emit the buffered bytes of an open sequence raw and close it
  task automatic flush_pending();
    int i;
    for (i = 0; i < seq_fill; i++) begin
      emit_result({13'd0, seq_bytes[i]}, LEN_ONE, 1'b1);
    end
    seq_fill = 0;
    seq_len  = LEN_NONE;
  endtask

  // Decode a byte outside any sequence
  task automatic open_or_pass(input logic [BYTE_W-1:0] b);
    casez (b)
      8'b0???????: emit_result({13'd0, b}, LEN_ONE, 1'b0);
      8'b110?????: seq_len = LEN_TWO;
      8'b1110????: seq_len = LEN_THREE;
      8'b11110???: seq_len = LEN_FOUR;
      default:     emit_result({13'd0, b}, LEN_ONE, 1'b1);
    endcase
    if (seq_len != LEN_NONE) begin
      seq_bytes[0] = b;
      seq_fill     = 1;
    end
  endtask

  // Work out the results one accepted byte request causes
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
    logic [CP_W-1:0] cp;
    run_n = 0;
    if (seq_len != LEN_NONE && (b & MASK_CONT) == CONT_MARK) begin
      if (seq_fill + 1 >= int'(seq_len)) begin
        case (seq_len)
          LEN_TWO:   cp = {10'd0, seq_bytes[0][4:0], b[5:0]};
          LEN_THREE: cp = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], b[5:0]};
          default:   cp = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0], b[5:0]};
        endcase
        emit_result(cp, seq_len, 1'b0);
        seq_fill = 0;
        seq_len  = LEN_NONE;
      end else begin
        seq_bytes[seq_fill] = b;
        seq_fill++;
      end
    end else begin
      if (seq_len != LEN_NONE) begin
        flush_pending();
      end
      open_or_pass(b);
    end
    if (eot && seq_len != LEN_NONE) begin
      flush_pending();
    end
    if (run_n > 0) begin
      run_res[run_n-1].last_of_run = 1'b1;
    end
  endtask

  // Offer one byte request, hold it until taken, then queue its results
  task automatic send_row(input stim_row_t r);
    int i;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_chan.valid <= 1'b0;
      @(posedge clk);
    end
    byte_chan.valid       <= 1'b1;
    byte_chan.byte_value  <= r.data;
    byte_chan.end_of_text <= r.eot;
    @(posedge clk);
    while (!byte_chan.ready) begin
      @(posedge clk);
    end
    decode_byte(r.data, r.eot);
    if (r.fixed) begin
      for (i = 0; i < r.nres; i++) begin
        code_points_due.push_back(r.res[i]);
      end
    end else begin
      for (i = 0; i < run_n; i++) begin
        code_points_due.push_back(run_res[i]);
      end
    end
  endtask

  // Send random text: mostly whole characters, some noise and cut sequences
  task automatic send_text(input int nbytes);
    int sent;
    int kind;
    int len;
    int i;
    logic [BYTE_W-1:0] chunk [4];
    sent = 0;
    while (sent < nbytes) begin
      kind = $urandom_range(99);
      for (i = 1; i < 4; i++) begin
        chunk[i] = 8'h80 | 8'($urandom_range(63));
      end
      if (kind < 20) begin
        len      = 1;
        chunk[0] = 8'($urandom_range(127));
      end else if (kind < 40) begin
        len      = 2;
        chunk[0] = 8'hC0 | 8'($urandom_range(31));
      end else if (kind < 58) begin
        len      = 3;
        chunk[0] = 8'hE0 | 8'($urandom_range(15));
      end else if (kind < 76) begin
        len      = 4;
        chunk[0] = 8'hF0 | 8'($urandom_range(7));
      end else if (kind < 88) begin
        len      = 1;
        chunk[0] = 8'($urandom_range(255));
      end else begin
        // cut a sequence short so the next character breaks it
        len      = $urandom_range(4, 2);
        chunk[0] = (len == 2) ? (8'hC0 | 8'($urandom_range(31))) :
                   (len == 3) ? (8'hE0 | 8'($urandom_range(15))) :
                                (8'hF0 | 8'($urandom_range(7)));
        len      = $urandom_range(len - 1, 1);
      end
      for (i = 0; i < len; i++) begin
        send_row(row_plain(chunk[i], $urandom_range(99) < 4));
        sent++;
      end
    end
  endtask

  // Stop offering and wait until every queued result has come
  task automatic drain_results();
    int n;
    byte_chan.valid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (code_points_due.size() != 0 && n < DRAIN_LIMIT);
    if (code_points_due.size() != 0) begin
      report_mismatch("results still missing", code_points_due.size(), 0);
      code_points_due.delete();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_chan.ready <= 1'b0;
      end else begin
        result_chan.ready <= !($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_chan.valid && result_chan.ready) begin
      if (code_points_due.size() == 0) begin
        report_mismatch("unexpected result code_point", result_chan.code_point, 0);
      end else begin
        want = code_points_due.pop_front();
        if (result_chan.code_point !== want.code_point)
          report_mismatch("code_point", result_chan.code_point, want.code_point);
        if (result_chan.byte_count !== want.byte_count)
          report_mismatch("byte_count", result_chan.byte_count, want.byte_count);
        if (result_chan.passed_through !== want.passed_through)
          report_mismatch("passed_through", result_chan.passed_through,
                          want.passed_through);
        if (result_chan.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", result_chan.last_of_run, want.last_of_run);
      end
    end
  end

  // Main sequence
  initial begin
    int p;
    rst                   <= 1'b1;
    byte_chan.valid       <= 1'b0;
    byte_chan.byte_value  <= '0;
    byte_chan.end_of_text <= 1'b0;
    seq_fill = 0;
    seq_len  = LEN_NONE;

    // ASCII extremes, lone continuation, invalid leads
    directed_rows.push_back(row_exp(8'h00, 1'b0, 3'd1, mk_res(21'h00, LEN_ONE, 1'b0, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    directed_rows.push_back(row_exp(8'h7F, 1'b0, 3'd1, mk_res(21'h7F, LEN_ONE, 1'b0, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    directed_rows.push_back(row_exp(8'h80, 1'b0, 3'd1, mk_res(21'h80, LEN_ONE, 1'b1, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    directed_rows.push_back(row_exp(8'hF8, 1'b0, 3'd1, mk_res(21'hF8, LEN_ONE, 1'b1, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    directed_rows.push_back(row_exp(8'hFF, 1'b0, 3'd1, mk_res(21'hFF, LEN_ONE, 1'b1, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    // two byte character; the lead alone yields nothing
    directed_rows.push_back(row_exp(8'hC2, 1'b0, 3'd0, NO_RES, NO_RES, NO_RES, NO_RES));
    directed_rows.push_back(row_exp(8'hA9, 1'b0, 3'd1, mk_res(21'hA9, LEN_TWO, 1'b0, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    // three byte character
    directed_rows.push_back(row_plain(8'hE2, 1'b0));
    directed_rows.push_back(row_plain(8'h82, 1'b0));
    directed_rows.push_back(row_plain(8'hAC, 1'b0));
    // largest four byte code point
    directed_rows.push_back(row_plain(8'hF7, 1'b0));
    directed_rows.push_back(row_plain(8'hBF, 1'b0));
    directed_rows.push_back(row_plain(8'hBF, 1'b0));
    directed_rows.push_back(row_exp(8'hBF, 1'b0, 3'd1,
                                    mk_res(21'h1FFFFF, LEN_FOUR, 1'b0, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    // four byte sequence broken by ASCII: three raw bytes, then the ASCII
    directed_rows.push_back(row_plain(8'hF0, 1'b0));
    directed_rows.push_back(row_plain(8'h90, 1'b0));
    directed_rows.push_back(row_plain(8'h80, 1'b0));
    directed_rows.push_back(row_exp(8'h41, 1'b0, 3'd4,
                                    mk_res(21'hF0, LEN_ONE, 1'b1, 1'b0),
                                    mk_res(21'h90, LEN_ONE, 1'b1, 1'b0),
                                    mk_res(21'h80, LEN_ONE, 1'b1, 1'b0),
                                    mk_res(21'h41, LEN_ONE, 1'b0, 1'b1)));
    // end of text on an open sequence flushes it raw
    directed_rows.push_back(row_exp(8'hC3, 1'b1, 3'd1, mk_res(21'hC3, LEN_ONE, 1'b1, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    directed_rows.push_back(row_plain(8'hE0, 1'b0));
    directed_rows.push_back(row_exp(8'hA0, 1'b1, 3'd2,
                                    mk_res(21'hE0, LEN_ONE, 1'b1, 1'b0),
                                    mk_res(21'hA0, LEN_ONE, 1'b1, 1'b1),
                                    NO_RES, NO_RES));
    // sequence broken by a new lead, which then completes
    directed_rows.push_back(row_plain(8'hE0, 1'b0));
    directed_rows.push_back(row_exp(8'hC0, 1'b0, 3'd1, mk_res(21'hE0, LEN_ONE, 1'b1, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    directed_rows.push_back(row_exp(8'h80, 1'b0, 3'd1, mk_res(21'h00, LEN_TWO, 1'b0, 1'b1),
                                    NO_RES, NO_RES, NO_RES));
    // end of text with nothing open
    directed_rows.push_back(row_exp(8'hFF, 1'b1, 3'd1, mk_res(21'hFF, LEN_ONE, 1'b1, 1'b1),
                                    NO_RES, NO_RES, NO_RES));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table with no idling
    foreach (directed_rows[i]) begin
      send_row(directed_rows[i]);
    end
    drain_results();

    // Random text: no idling, sender idle, receiver stalling, both
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 84 : (p == 3) ? 14 : 0;
      recv_stall_pct = (p == 2) ? 84 : (p == 3) ? 14 : 0;
      send_text(70);
      drain_results();
    end

    // Hold the receiver off while the sender keeps offering requests
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    send_text(60);
    drain_results();

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
hdl/u8dec_pkg.sv
hdl/u8dec_byte_if.sv
hdl/u8dec_result_if.sv
hdl/utf8_stream_decoder_unit.sv
tb/tb_top.sv
